### rtl/ts_continuity_counter_check_assert.svh
// assertion macros for the continuity counter checker
`ifndef TS_CONTINUITY_COUNTER_CHECK_ASSERT_SVH
`define TS_CONTINUITY_COUNTER_CHECK_ASSERT_SVH

`ifndef SYNTHESIS

`define TSCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("continuity checker assertion failed");

`define TSCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("continuity checker assertion failed");

`else

`define TSCC_ASSERT_IMP(lbl, ante, cons)

`define TSCC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### rtl/ts_cc_pkg.sv
// types and constants shared by the continuity counter checker
`timescale 1ns / 1ps

package ts_cc_pkg;

  localparam logic [12:0] NULL_PID = 13'h1fff;
  localparam logic [12:0] SKIP_PID = 13'h00ff;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_LIST   = 1'b1;

  localparam logic [1:0] ADAPT_RESERVED   = 2'd0;
  localparam logic [1:0] ADAPT_PAYLOAD    = 2'd1;
  localparam logic [1:0] ADAPT_FIELD_ONLY = 2'd2;
  localparam logic [1:0] ADAPT_BOTH       = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [1:0]  channel;
    logic [12:0] pid;
    logic [3:0]  continuity;
    logic [1:0]  adaptation_control;
    logic        discontinuity;
    logic        sync_matched;
    logic [4:0]  list_index;
    logic        entry_valid;
  } ts_cc_in_t;

  typedef struct packed {
    logic        tracked;
    logic        cc_error;
    logic [31:0] error_total;
  } ts_cc_out_t;

  typedef struct packed {
    logic        valid;
    logic [12:0] pid;
  } ts_cc_list_t;

  typedef struct packed {
    logic        used;
    logic [12:0] pid;
    logic [3:0]  count;
    logic        disc;
  } ts_cc_slot_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LSCAN,
    ST_TSCAN,
    ST_UPDATE
  } ts_cc_state_t;

endpackage

### rtl/ts_cc_ram.sv
// simple dual-port ram, one write and one registered read per cycle
`timescale 1ns / 1ps

module ts_cc_ram #(
  parameter int WIDTH = 8,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/ts_continuity_counter_check.sv
// top level of the transport stream continuity counter checker
//
//   channel  ports                 handshake
//   input    in_item               beat taken when start && !busy
//   result   out_result            one-cycle strobe out_valid, no stall
//
// list writes, bad channels and gated-off packets: result registered, shown in the cycle after the beat
// listed packets: list scan, slot scan, one update state, then the result;
//   each scan walks one ram read port per entry
// after reset both rams are swept once over 2**(channel bits + slot bits) addresses
//   (128 at default sizes), with busy high
// the result strobe cannot be held off; a new beat is taken while it shows
`timescale 1ns / 1ps

`include "ts_continuity_counter_check_assert.svh"

module ts_continuity_counter_check
  import ts_cc_pkg::*;
#(
  parameter int CHANNELS    = 4,
  parameter int TRACK_SLOTS = 32,
  parameter int LIST_SLOTS  = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  ts_cc_in_t  in_item,
  output logic       out_valid,
  output ts_cc_out_t out_result
);

  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LW  = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
  localparam int TW  = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int SW  = (LW > TW) ? LW : TW;
  localparam int LAW = CHW + LW;
  localparam int TAW = CHW + TW;
  localparam int CW  = (LAW > TAW) ? LAW : TAW;

  localparam logic [SW-1:0] LIST_LAST  = SW'(LIST_SLOTS - 1);
  localparam logic [SW-1:0] TRACK_LAST = SW'(TRACK_SLOTS - 1);

  ts_cc_state_t state_r, state_nxt;

  ts_cc_in_t        item_r, item_nxt;
  logic [CHW-1:0]   ch_r, ch_nxt;
  logic [SW-1:0]    idx_r, idx_nxt;
  logic             iss_done_r, iss_done_nxt;
  logic             pv_r, pv_nxt;
  logic             plast_r, plast_nxt;
  logic [SW-1:0]    pidx_r, pidx_nxt;
  logic             have_free_r, have_free_nxt;
  logic [TW-1:0]    free_r, free_nxt;
  logic             hit_r, hit_nxt;
  logic [TW-1:0]    hit_idx_r, hit_idx_nxt;
  logic [3:0]       hit_cnt_r, hit_cnt_nxt;
  logic             hit_disc_r, hit_disc_nxt;
  logic [CW-1:0]    clr_r, clr_nxt;
  logic [31:0]      err_cnt_r [CHANNELS];
  logic [31:0]      err_cnt_nxt;
  logic             err_we;
  logic             out_valid_r, out_valid_nxt;
  ts_cc_out_t       out_r, out_nxt;

  logic             l_we;
  logic [LAW-1:0]   l_waddr, l_raddr;
  ts_cc_list_t      l_wdata, l_rdata;
  logic             t_we;
  logic [TAW-1:0]   t_waddr, t_raddr;
  ts_cc_slot_t      t_wdata, t_rdata;

  logic [CHW+1:0]   ch_ext;
  logic [CHW-1:0]   ch_in;
  logic [LW+4:0]    lidx_ext;
  logic             accept, ch_ok, lidx_ok, gate_ok;
  logic             l_match, t_match, t_free;
  logic [3:0]       cc_next, new_cnt;
  logic             cc_err;
  logic [SW-1:0]    scan_last;

  assign ch_ext   = {CHW'(0), in_item.channel};
  assign ch_in    = ch_ext[CHW-1:0];
  assign lidx_ext = {LW'(0), in_item.list_index};
  assign accept   = start && (state_r == ST_IDLE);
  assign ch_ok    = 32'(in_item.channel) < CHANNELS;
  assign lidx_ok  = 32'(in_item.list_index) < LIST_SLOTS;
  assign gate_ok  = in_item.sync_matched && (in_item.pid != NULL_PID) &&
                    (in_item.pid != SKIP_PID);

  assign l_raddr = {ch_r, idx_r[LW-1:0]};
  assign t_raddr = {ch_r, idx_r[TW-1:0]};

  assign l_match = pv_r && l_rdata.valid && (l_rdata.pid == item_r.pid);
  assign t_match = pv_r && t_rdata.used && (t_rdata.pid == item_r.pid);
  assign t_free  = pv_r && !t_rdata.used;

  assign cc_next = hit_cnt_r + 4'd1;
  assign scan_last = (state_r == ST_LSCAN) ? LIST_LAST : TRACK_LAST;

  always_comb begin
    cc_err = 1'b0;
    case (item_r.adaptation_control)
      ADAPT_PAYLOAD:    cc_err = item_r.continuity != cc_next;
      ADAPT_FIELD_ONLY: cc_err = item_r.discontinuity ? (item_r.continuity == cc_next)
                                                      : (item_r.continuity != hit_cnt_r);
      ADAPT_BOTH:       cc_err = !item_r.discontinuity && !hit_disc_r &&
                                 (item_r.continuity != cc_next);
      ADAPT_RESERVED:   cc_err = 1'b0;
      default:          cc_err = 1'b0;
    endcase
  end

  assign new_cnt = (((item_r.adaptation_control == ADAPT_PAYLOAD) ||
                     (item_r.adaptation_control == ADAPT_BOTH)) && !item_r.discontinuity)
                   ? item_r.continuity : hit_cnt_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && ch_ok && (in_item.kind == KIND_PACKET) && gate_ok) begin
          state_nxt = ST_LSCAN;
        end
      end
      ST_LSCAN: begin
        if (l_match) begin
          state_nxt = ST_TSCAN;
        end else if (pv_r && plast_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TSCAN: begin
        if (t_match || (pv_r && plast_r)) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    item_nxt      = item_r;
    ch_nxt        = ch_r;
    idx_nxt       = idx_r;
    iss_done_nxt  = iss_done_r;
    pv_nxt        = 1'b0;
    plast_nxt     = plast_r;
    pidx_nxt      = pidx_r;
    have_free_nxt = have_free_r;
    free_nxt      = free_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_cnt_nxt   = hit_cnt_r;
    hit_disc_nxt  = hit_disc_r;
    clr_nxt       = clr_r;
    err_we        = 1'b0;
    err_cnt_nxt   = '0;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    l_we          = 1'b0;
    l_waddr       = {ch_in, lidx_ext[LW-1:0]};
    l_wdata       = '{valid: in_item.entry_valid, pid: in_item.pid};
    t_we          = 1'b0;
    t_waddr       = {ch_r, hit_idx_r};
    t_wdata       = '{used: 1'b1, pid: item_r.pid, count: new_cnt,
                      disc: item_r.discontinuity};
    case (state_r)
      ST_CLEAR: begin
        l_we    = 1'b1;
        l_waddr = clr_r[LAW-1:0];
        l_wdata = '0;
        t_we    = 1'b1;
        t_waddr = clr_r[TAW-1:0];
        t_wdata = '0;
        clr_nxt = clr_r + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          item_nxt     = in_item;
          ch_nxt       = ch_in;
          idx_nxt      = '0;
          iss_done_nxt = 1'b0;
          if (!ch_ok) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
          end else if (in_item.kind == KIND_LIST) begin
            l_we          = lidx_ok;
            out_valid_nxt = 1'b1;
            out_nxt       = '{tracked: 1'b0, cc_error: 1'b0, error_total: err_cnt_r[ch_in]};
          end else if (!gate_ok) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{tracked: 1'b0, cc_error: 1'b0, error_total: err_cnt_r[ch_in]};
          end
        end
      end
      ST_LSCAN, ST_TSCAN: begin
        if (!iss_done_r) begin
          pv_nxt       = 1'b1;
          plast_nxt    = idx_r == scan_last;
          pidx_nxt     = idx_r;
          idx_nxt      = idx_r + 1'b1;
          iss_done_nxt = idx_r == scan_last;
        end
        if (state_r == ST_LSCAN) begin
          if (l_match) begin
            pv_nxt        = 1'b0;
            idx_nxt       = '0;
            iss_done_nxt  = 1'b0;
            have_free_nxt = 1'b0;
            hit_nxt       = 1'b0;
          end else if (pv_r && plast_r) begin
            pv_nxt        = 1'b0;
            out_valid_nxt = 1'b1;
            out_nxt       = '{tracked: 1'b0, cc_error: 1'b0, error_total: err_cnt_r[ch_r]};
          end
        end else begin
          if (t_match) begin
            pv_nxt       = 1'b0;
            hit_nxt      = 1'b1;
            hit_idx_nxt  = pidx_r[TW-1:0];
            hit_cnt_nxt  = t_rdata.count;
            hit_disc_nxt = t_rdata.disc;
          end else begin
            if (t_free && !have_free_r) begin
              have_free_nxt = 1'b1;
              free_nxt      = pidx_r[TW-1:0];
            end
            if (pv_r && plast_r) begin
              pv_nxt = 1'b0;
            end
          end
        end
      end
      ST_UPDATE: begin
        out_valid_nxt = 1'b1;
        if (hit_r) begin
          t_we        = 1'b1;
          err_we      = 1'b1;
          err_cnt_nxt = (cc_err && (err_cnt_r[ch_r] != '1)) ? err_cnt_r[ch_r] + 32'd1
                                                            : err_cnt_r[ch_r];
          out_nxt     = '{tracked: 1'b1, cc_error: cc_err, error_total: err_cnt_nxt};
        end else begin
          t_we    = have_free_r;
          t_waddr = {ch_r, free_r};
          t_wdata = '{used: 1'b1, pid: item_r.pid, count: item_r.continuity,
                      disc: item_r.discontinuity};
          out_nxt = '{tracked: 1'b0, cc_error: 1'b0, error_total: err_cnt_r[ch_r]};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        err_cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      if (err_we) begin
        err_cnt_r[ch_r] <= err_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    ch_r        <= ch_nxt;
    idx_r       <= idx_nxt;
    iss_done_r  <= iss_done_nxt;
    plast_r     <= plast_nxt;
    pidx_r      <= pidx_nxt;
    have_free_r <= have_free_nxt;
    free_r      <= free_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_cnt_r   <= hit_cnt_nxt;
    hit_disc_r  <= hit_disc_nxt;
    out_r       <= out_nxt;
  end

  ts_cc_ram #(
    .WIDTH ($bits(ts_cc_list_t)),
    .AW    (LAW)
  ) u_list_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  ts_cc_ram #(
    .WIDTH ($bits(ts_cc_slot_t)),
    .AW    (TAW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  assign busy       = state_r != ST_IDLE;
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  `TSCC_ASSERT_NXT(a_beat_answered, start && !busy, busy || out_valid)
  `TSCC_ASSERT_IMP(a_err_needs_track, out_valid && out_result.cc_error, out_result.tracked)
  `TSCC_ASSERT_IMP(a_err_counted, out_valid && out_result.cc_error,
                   out_result.error_total != 32'd0)

endmodule
